// ===== sv/rpa_pkg.sv =====
// Shared types and constants for the reference-counted page allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package rpa_pkg;

   localparam int ADDR_W   = 24;
   localparam int FUNC_W   = 3;
   localparam int COUNT_W  = 8;
   localparam int FREE_W   = 13;
   localparam int STATUS_W = 2;

   localparam int NUM_PAGES_DEF  = 4096;
   localparam int PAGE_SHIFT_DEF = 12;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE      = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INCREMENT = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ_CNT  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ_FREE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADADDR  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic accept;
      logic commit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== sv/rpa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the free stack and the reference count table.
`default_nettype none

module rpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/rpa_ctrl.sv =====
// Controller state machine of the page allocator: clearing pass, request
// accept, commit and result valid. Depends on rpa_pkg.
`default_nettype none

module rpa_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire rpa_pkg::dp_sts_type sts,
   output      rpa_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      cmd.clear  = (state_ff == S_CLEAR);
      cmd.accept = (state_ff == S_IDLE) && req_valid;
      // The result register is free when empty or being taken this cycle.
      cmd.commit = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);

      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd.accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd.commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== sv/rpa_dp.sv =====
// Datapath of the page allocator: request registers, stack pointer, the free
// stack and reference count memories, and the result registers.
// Depends on rpa_pkg and rpa_ram.
`default_nettype none

module rpa_dp #(
   parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
   parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [rpa_pkg::ADDR_W-1:0]      csr_wr_data,
   input  wire logic [rpa_pkg::FUNC_W-1:0]      req_func,
   input  wire logic [rpa_pkg::ADDR_W-1:0]      req_page_addr,
   input  wire rpa_pkg::ctrl_cmd_type           cmd,
   output      rpa_pkg::dp_sts_type             sts,
   output      logic [rpa_pkg::ADDR_W-1:0]      rsp_alloc_addr,
   output      logic [rpa_pkg::COUNT_W-1:0]     rsp_ref_count,
   output      logic [rpa_pkg::FREE_W-1:0]      rsp_free_pages,
   output      logic [rpa_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int IDX_W  = $clog2(NUM_PAGES);
   localparam int TOP_W  = $clog2(NUM_PAGES + 1);
   localparam int PNUM_W = rpa_pkg::ADDR_W - PAGE_SHIFT;
   localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(NUM_PAGES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_PAGES - 1);

   logic [rpa_pkg::ADDR_W-1:0]   first_usable_ff;
   logic [TOP_W-1:0]             top_ff;
   logic [TOP_W-1:0]             top_in;
   logic [IDX_W-1:0]             clr_idx_ff;
   logic [rpa_pkg::FUNC_W-1:0]   func_ff;
   logic [rpa_pkg::ADDR_W-1:0]   addr_ff;

   logic [rpa_pkg::ADDR_W-1:0]   alloc_addr_ff, alloc_addr_in;
   logic [rpa_pkg::COUNT_W-1:0]  ref_count_ff, ref_count_in;
   logic [rpa_pkg::FREE_W-1:0]   free_pages_ff, free_pages_in;
   logic [rpa_pkg::STATUS_W-1:0] status_ff, status_in;

   logic [PNUM_W-1:0]            pnum_req;
   logic [PNUM_W-1:0]            pnum_cur;
   logic [31:0]                  pnum_req_wide;
   logic [31:0]                  pnum_cur_wide;
   logic [IDX_W-1:0]             idx_req;
   logic [IDX_W-1:0]             idx_cur;
   logic                         in_range;
   logic                         aligned;
   logic                         below_first;
   logic [TOP_W-1:0]             top_m1;

   logic                         rc_we;
   logic [IDX_W-1:0]             rc_wa;
   logic [rpa_pkg::COUNT_W-1:0]  rc_wd;
   logic [IDX_W-1:0]             rc_ra;
   logic [rpa_pkg::COUNT_W-1:0]  rc_rd;
   logic                         stk_we;
   logic [IDX_W-1:0]             stk_rd;

   logic [rpa_pkg::COUNT_W-1:0]  new_count;
   logic [31:0]                  alloc_wide;
   logic [31:0]                  top_wide;

   always_comb begin
      pnum_req      = req_page_addr[rpa_pkg::ADDR_W-1:PAGE_SHIFT];
      pnum_cur      = addr_ff[rpa_pkg::ADDR_W-1:PAGE_SHIFT];
      pnum_req_wide = 32'(pnum_req);
      pnum_cur_wide = 32'(pnum_cur);
      idx_req       = pnum_req_wide[IDX_W-1:0];
      idx_cur       = pnum_cur_wide[IDX_W-1:0];
      in_range      = pnum_cur_wide < 32'(NUM_PAGES);
      aligned       = (addr_ff[PAGE_SHIFT-1:0] == '0);
      below_first   = addr_ff < first_usable_ff;
      top_m1        = top_ff - TOP_W'(1);
      // The count of the request's page is read in the accept cycle and
      // read again from the held address while the result register is busy.
      rc_ra         = cmd.accept ? idx_req : idx_cur;
   end

   rpa_ram #(
      .WIDTH (rpa_pkg::COUNT_W),
      .DEPTH (NUM_PAGES)
   ) u_refcount (
      .clock   (clock),
      .wr_en   (rc_we),
      .wr_addr (rc_wa),
      .wr_data (rc_wd),
      .rd_addr (rc_ra),
      .rd_data (rc_rd)
   );

   rpa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NUM_PAGES)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (top_ff[IDX_W-1:0]),
      .wr_data (idx_cur),
      .rd_addr (top_m1[IDX_W-1:0]),
      .rd_data (stk_rd)
   );

   always_comb begin
      top_in        = top_ff;
      rc_we         = 1'b0;
      rc_wa         = idx_cur;
      rc_wd         = '0;
      stk_we        = 1'b0;
      new_count     = '0;
      alloc_addr_in = '0;
      ref_count_in  = '0;
      status_in     = rpa_pkg::ST_OK;
      alloc_wide    = 32'(stk_rd) << PAGE_SHIFT;

      case (func_ff)
         rpa_pkg::FUNC_ALLOC: begin
            if (top_ff == '0) begin
               status_in = rpa_pkg::ST_OOM;
            end else begin
               top_in        = top_m1;
               rc_we         = 1'b1;
               rc_wa         = stk_rd;
               rc_wd         = rpa_pkg::COUNT_W'(1);
               ref_count_in  = rpa_pkg::COUNT_W'(1);
               alloc_addr_in = alloc_wide[rpa_pkg::ADDR_W-1:0];
            end
         end
         rpa_pkg::FUNC_FREE: begin
            if (!aligned || below_first || !in_range) begin
               status_in = rpa_pkg::ST_BADADDR;
            end else begin
               new_count    = (rc_rd != '0) ? rc_rd - rpa_pkg::COUNT_W'(1) : '0;
               rc_we        = 1'b1;
               rc_wd        = new_count;
               ref_count_in = new_count;
               if (new_count == '0) begin
                  if (top_ff >= TOP_FULL) begin
                     status_in = rpa_pkg::ST_OVERFLOW;
                  end else begin
                     stk_we = 1'b1;
                     top_in = top_ff + TOP_W'(1);
                  end
               end
            end
         end
         rpa_pkg::FUNC_INCREMENT: begin
            if (!in_range) begin
               status_in = rpa_pkg::ST_BADADDR;
            end else begin
               new_count    = (rc_rd != rpa_pkg::COUNT_MAX) ?
                              rc_rd + rpa_pkg::COUNT_W'(1) : rc_rd;
               rc_we        = 1'b1;
               rc_wd        = new_count;
               ref_count_in = new_count;
            end
         end
         rpa_pkg::FUNC_READ_CNT: begin
            if (!in_range) begin
               status_in = rpa_pkg::ST_BADADDR;
            end else begin
               ref_count_in = rc_rd;
            end
         end
         default: begin
         end
      endcase

      top_wide      = 32'(top_in);
      free_pages_in = top_wide[rpa_pkg::FREE_W-1:0];

      // Nothing takes effect until the controller commits the request.
      rc_we  = rc_we && cmd.commit;
      stk_we = stk_we && cmd.commit;

      // The clearing pass after reset owns the count table's write port.
      if (cmd.clear) begin
         rc_we = 1'b1;
         rc_wa = clr_idx_ff;
         rc_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_usable_ff <= '0;
         top_ff          <= '0;
         clr_idx_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            first_usable_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            top_ff <= top_in;
         end
         if (cmd.clear) begin
            clr_idx_ff <= clr_idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_func;
         addr_ff <= req_page_addr;
      end
      if (cmd.commit) begin
         alloc_addr_ff <= alloc_addr_in;
         ref_count_ff  <= ref_count_in;
         free_pages_ff <= free_pages_in;
         status_ff     <= status_in;
      end
   end

   assign sts.clear_last  = (clr_idx_ff == IDX_LAST);
   assign rsp_alloc_addr  = alloc_addr_ff;
   assign rsp_ref_count   = ref_count_ff;
   assign rsp_free_pages  = free_pages_ff;
   assign rsp_status      = status_ff;

endmodule

`default_nettype wire

// ===== sv/refcounted_page_allocator.sv =====
// Reference-counted page-frame allocator: top level joining controller and datapath.
// A request is held in the request registers and its result is registered on commit,
// once the result register is free; rsp_valid rises with that result. req_stall stays
// high until the commit, as the read-modify-write of the count and stack memories
// takes one request at a time. After reset a clearing pass zeroes the count table,
// while req_stall is high; the free stack is empty and first_usable_addr is zero.
`default_nettype none

module refcounted_page_allocator #(
   parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
   parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [rpa_pkg::ADDR_W-1:0]   csr_wr_data,
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic [rpa_pkg::FUNC_W-1:0]   req_func,
   input  wire logic [rpa_pkg::ADDR_W-1:0]   req_page_addr,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic [rpa_pkg::ADDR_W-1:0]   rsp_alloc_addr,
   output      logic [rpa_pkg::COUNT_W-1:0]  rsp_ref_count,
   output      logic [rpa_pkg::FREE_W-1:0]   rsp_free_pages,
   output      logic [rpa_pkg::STATUS_W-1:0] rsp_status
);

   rpa_pkg::ctrl_cmd_type cmd;
   rpa_pkg::dp_sts_type   sts;

   rpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rpa_dp #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_func       (req_func),
      .req_page_addr  (req_page_addr),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_alloc_addr (rsp_alloc_addr),
      .rsp_ref_count  (rsp_ref_count),
      .rsp_free_pages (rsp_free_pages),
      .rsp_status     (rsp_status)
   );

   // A new result appears only as the registered outcome of a commit.
   a_valid_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit))
      else $error("rsp_valid rose without a commit");

   // No request is taken while the count table is being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> req_stall)
      else $error("request accepted during clearing pass");

   // An accepted request is committed before another one can be taken.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> req_stall)
      else $error("second request accepted before commit");

   // An out-of-memory result carries neither an address nor a count.
   a_oom_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rpa_pkg::ST_OOM) |->
         (rsp_alloc_addr == '0) && (rsp_ref_count == '0))
      else $error("out-of-memory result with nonzero payload");

endmodule

`default_nettype wire
